### src/stc_pkg.sv
// Shared types, token codes and character helpers for the source tokenizer.
// Used by stc_lexer, stc_out_fifo and source_tokenizer_core; no dependencies.
package stc_pkg;

  // Default width of line, column and length counters
  localparam int unsigned POS_WIDTH_DEF = 16;

  // Result buffer depth (power of two)
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_LW    = $clog2(FIFO_DEPTH + 1);

  // Output field widths
  localparam int unsigned OUT_POS_W  = 16;

  // Characters with special meaning
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Token kinds
  typedef enum logic [4:0] {
    K_LPAREN  = 5'd0,
    K_RPAREN  = 5'd1,
    K_LBRACE  = 5'd2,
    K_RBRACE  = 5'd3,
    K_LBRACK  = 5'd4,
    K_RBRACK  = 5'd5,
    K_COMMA   = 5'd6,
    K_ASSIGN  = 5'd7,
    K_EQ      = 5'd8,
    K_UNDER   = 5'd9,
    K_PLUS    = 5'd10,
    K_MINUS   = 5'd11,
    K_ARROW   = 5'd12,
    K_STAR    = 5'd13,
    K_SLASH   = 5'd14,
    K_PERCENT = 5'd15,
    K_SEMI    = 5'd16,
    K_BANG    = 5'd17,
    K_NE      = 5'd18,
    K_LT      = 5'd19,
    K_LE      = 5'd20,
    K_GT      = 5'd21,
    K_GE      = 5'd22,
    K_COLON   = 5'd23,
    K_STRING  = 5'd24,
    K_INT     = 5'd25,
    K_FLOAT   = 5'd26,
    K_IDENT   = 5'd27,
    K_EOF     = 5'd28,
    K_ERR     = 5'd29
  } kind_e;

  // Pending-token mode
  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_EQ     = 4'd1,
    M_BANG   = 4'd2,
    M_LT     = 4'd3,
    M_GT     = 4'd4,
    M_MINUS  = 4'd5,
    M_UNDER  = 4'd6,
    M_IDENT  = 4'd7,
    M_INT    = 4'd8,
    M_FLOAT  = 4'd9,
    M_STRING = 4'd10
  } mode_e;

  // One result beat
  typedef struct packed {
    kind_e                 kind;
    logic [OUT_POS_W-1:0]  line;
    logic [OUT_POS_W-1:0]  col;
    logic [OUT_POS_W-1:0]  len;
    logic                  last;
  } token_t;

  // Single-character token lookup
  typedef struct packed {
    logic  hit;
    kind_e kind;
  } single_t;

  // Result buffer status
  typedef struct packed {
    logic               valid;
    logic               room2;
    logic [FIFO_LW-1:0] level;
  } fifo_stat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic single_t single_kind(input logic [7:0] c);
    single_t s;
    s.hit  = 1'b1;
    s.kind = K_LPAREN;
    unique case (c)
      8'h28:   s.kind = K_LPAREN;
      8'h29:   s.kind = K_RPAREN;
      8'h7B:   s.kind = K_LBRACE;
      8'h7D:   s.kind = K_RBRACE;
      8'h5B:   s.kind = K_LBRACK;
      8'h5D:   s.kind = K_RBRACK;
      8'h2C:   s.kind = K_COMMA;
      8'h2B:   s.kind = K_PLUS;
      8'h2A:   s.kind = K_STAR;
      8'h2F:   s.kind = K_SLASH;
      8'h25:   s.kind = K_PERCENT;
      8'h3B:   s.kind = K_SEMI;
      8'h3A:   s.kind = K_COLON;
      default: s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

### src/stc_lexer.sv
// Lexer state and per-character next-state logic; yields up to two tokens.
// Depends on stc_pkg.
module stc_lexer #(
  parameter int unsigned POS_WIDTH = stc_pkg::POS_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,      // process the held character this cycle
  input  logic [7:0]      ch_i,
  input  logic            eoi_i,
  output stc_pkg::token_t res_o [2],
  output logic [1:0]      res_cnt_o,
  output stc_pkg::mode_e  lex_mode_o
);

  localparam logic [POS_WIDTH-1:0] ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] TWO = POS_WIDTH'(2);

  stc_pkg::mode_e        mode_q, mode_d;
  logic [POS_WIDTH-1:0]  cur_line_q, cur_line_d;
  logic [POS_WIDTH-1:0]  cur_col_q, cur_col_d;
  logic [POS_WIDTH-1:0]  tok_line_q, tok_line_d;
  logic [POS_WIDTH-1:0]  tok_col_q, tok_col_d;
  logic [POS_WIDTH-1:0]  tok_len_q, tok_len_d;

  stc_pkg::token_t       res [2];
  logic [1:0]            n;
  logic                  restart;
  logic                  adv;
  stc_pkg::single_t      sk;
  stc_pkg::kind_e        op_one, op_two;

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic stc_pkg::token_t mk(input stc_pkg::kind_e k,
                                         input logic [POS_WIDTH-1:0] l,
                                         input logic [POS_WIDTH-1:0] c,
                                         input logic [POS_WIDTH-1:0] len);
    stc_pkg::token_t t;
    t.kind = k;
    t.line = stc_pkg::OUT_POS_W'(l);
    t.col  = stc_pkg::OUT_POS_W'(c);
    t.len  = stc_pkg::OUT_POS_W'(len);
    t.last = 1'b0;
    return t;
  endfunction

  assign sk = stc_pkg::single_kind(ch_i);

  // Kinds for the one-char operators that wait for a following '='
  always_comb begin
    unique case (mode_q)
      stc_pkg::M_EQ:   begin op_one = stc_pkg::K_ASSIGN; op_two = stc_pkg::K_EQ; end
      stc_pkg::M_BANG: begin op_one = stc_pkg::K_BANG;   op_two = stc_pkg::K_NE; end
      stc_pkg::M_LT:   begin op_one = stc_pkg::K_LT;     op_two = stc_pkg::K_LE; end
      default:         begin op_one = stc_pkg::K_GT;     op_two = stc_pkg::K_GE; end
    endcase
  end

  // Next state and emitted tokens
  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    res[0]     = '0;
    res[1]     = '0;
    n          = 2'd0;
    restart    = 1'b0;
    adv        = 1'b0;

    if (eoi_i) begin
      // flush pending token, then eof at the current position
      unique case (mode_q) inside
        stc_pkg::M_EQ, stc_pkg::M_BANG, stc_pkg::M_LT, stc_pkg::M_GT: begin
          res[0] = mk(op_one, tok_line_q, tok_col_q, ONE);
          n = 2'd1;
        end
        stc_pkg::M_MINUS: begin
          res[0] = mk(stc_pkg::K_MINUS, tok_line_q, tok_col_q, ONE);
          n = 2'd1;
        end
        stc_pkg::M_UNDER: begin
          res[0] = mk(stc_pkg::K_UNDER, tok_line_q, tok_col_q, ONE);
          n = 2'd1;
        end
        stc_pkg::M_IDENT: begin
          res[0] = mk(stc_pkg::K_IDENT, tok_line_q, tok_col_q, tok_len_q);
          n = 2'd1;
        end
        stc_pkg::M_INT: begin
          res[0] = mk(stc_pkg::K_INT, tok_line_q, tok_col_q, tok_len_q);
          n = 2'd1;
        end
        stc_pkg::M_FLOAT: begin
          res[0] = mk(stc_pkg::K_FLOAT, tok_line_q, tok_col_q, tok_len_q);
          n = 2'd1;
        end
        stc_pkg::M_STRING: begin
          res[0] = mk(stc_pkg::K_ERR, tok_line_q, tok_col_q, tok_len_q);
          n = 2'd1;
        end
        default: ;
      endcase
      res[n[0]] = mk(stc_pkg::K_EOF, cur_line_q, cur_col_q, '0);
      n = n + 2'd1;
      mode_d = stc_pkg::M_IDLE;
    end else begin
      unique case (mode_q) inside
        stc_pkg::M_EQ, stc_pkg::M_BANG, stc_pkg::M_LT, stc_pkg::M_GT: begin
          if (ch_i == stc_pkg::CH_EQ) begin
            res[0] = mk(op_two, tok_line_q, tok_col_q, TWO);
            n = 2'd1;
            mode_d = stc_pkg::M_IDLE;
            adv = 1'b1;
          end else begin
            res[0] = mk(op_one, tok_line_q, tok_col_q, ONE);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        stc_pkg::M_MINUS: begin
          if (ch_i == stc_pkg::CH_GT) begin
            res[0] = mk(stc_pkg::K_ARROW, tok_line_q, tok_col_q, TWO);
            n = 2'd1;
            mode_d = stc_pkg::M_IDLE;
            adv = 1'b1;
          end else begin
            res[0] = mk(stc_pkg::K_MINUS, tok_line_q, tok_col_q, ONE);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        stc_pkg::M_UNDER: begin
          if (stc_pkg::is_alpha(ch_i)) begin
            tok_len_d = sat_inc(tok_len_q);
            mode_d = stc_pkg::M_IDENT;
            adv = 1'b1;
          end else begin
            res[0] = mk(stc_pkg::K_UNDER, tok_line_q, tok_col_q, ONE);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        stc_pkg::M_IDENT: begin
          if (stc_pkg::is_alpha(ch_i) || stc_pkg::is_digit(ch_i) ||
              (ch_i == stc_pkg::CH_UNDER)) begin
            tok_len_d = sat_inc(tok_len_q);
            adv = 1'b1;
          end else begin
            res[0] = mk(stc_pkg::K_IDENT, tok_line_q, tok_col_q, tok_len_q);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        stc_pkg::M_INT: begin
          if (stc_pkg::is_digit(ch_i) || (ch_i == stc_pkg::CH_DOT)) begin
            tok_len_d = sat_inc(tok_len_q);
            if (ch_i == stc_pkg::CH_DOT) begin
              mode_d = stc_pkg::M_FLOAT;
            end
            adv = 1'b1;
          end else begin
            res[0] = mk(stc_pkg::K_INT, tok_line_q, tok_col_q, tok_len_q);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        stc_pkg::M_FLOAT: begin
          if (stc_pkg::is_digit(ch_i)) begin
            tok_len_d = sat_inc(tok_len_q);
            adv = 1'b1;
          end else begin
            res[0] = mk(stc_pkg::K_FLOAT, tok_line_q, tok_col_q, tok_len_q);
            n = 2'd1;
            restart = 1'b1;
          end
        end
        stc_pkg::M_STRING: begin
          if (ch_i == stc_pkg::CH_QUOTE) begin
            res[0] = mk(stc_pkg::K_STRING, tok_line_q, tok_col_q, tok_len_q);
            n = 2'd1;
            mode_d = stc_pkg::M_IDLE;
          end else if (ch_i == stc_pkg::CH_NL) begin
            // string left open at end of line
            res[0] = mk(stc_pkg::K_ERR, tok_line_q, tok_col_q, tok_len_q);
            n = 2'd1;
            mode_d = stc_pkg::M_IDLE;
          end else begin
            tok_len_d = sat_inc(tok_len_q);
          end
          adv = 1'b1;
        end
        default: restart = 1'b1;
      endcase

      // Character seen from idle, or one that ends the pending token: start a new token
      if (restart) begin
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
        tok_len_d  = ONE;
        mode_d     = stc_pkg::M_IDLE;
        adv        = 1'b1;
        if (sk.hit) begin
          res[n[0]] = mk(sk.kind, cur_line_q, cur_col_q, ONE);
          n = n + 2'd1;
        end else if (ch_i == stc_pkg::CH_EQ) begin
          mode_d = stc_pkg::M_EQ;
        end else if (ch_i == stc_pkg::CH_BANG) begin
          mode_d = stc_pkg::M_BANG;
        end else if (ch_i == stc_pkg::CH_LT) begin
          mode_d = stc_pkg::M_LT;
        end else if (ch_i == stc_pkg::CH_GT) begin
          mode_d = stc_pkg::M_GT;
        end else if (ch_i == stc_pkg::CH_MINUS) begin
          mode_d = stc_pkg::M_MINUS;
        end else if (ch_i == stc_pkg::CH_UNDER) begin
          mode_d = stc_pkg::M_UNDER;
        end else if (stc_pkg::is_alpha(ch_i)) begin
          mode_d = stc_pkg::M_IDENT;
        end else if (stc_pkg::is_digit(ch_i)) begin
          mode_d = stc_pkg::M_INT;
        end else if (ch_i == stc_pkg::CH_QUOTE) begin
          // text starts right after the opening quote
          tok_col_d = sat_inc(cur_col_q);
          tok_len_d = '0;
          mode_d    = stc_pkg::M_STRING;
        end
      end

      // Position of the next character
      if (adv) begin
        if (ch_i == stc_pkg::CH_NL) begin
          cur_line_d = sat_inc(cur_line_q);
          cur_col_d  = ONE;
        end else begin
          cur_col_d  = sat_inc(cur_col_q);
        end
      end
    end

    res[0].last = (n == 2'd1);
    res[1].last = (n == 2'd2);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= stc_pkg::M_IDLE;
      cur_line_q <= ONE;
      cur_col_q  <= ONE;
      tok_line_q <= ONE;
      tok_col_q  <= ONE;
      tok_len_q  <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
    end
  end

  assign res_o      = res;
  assign res_cnt_o  = fire_i ? n : 2'd0;
  assign lex_mode_o = mode_q;

endmodule

### src/stc_out_fifo.sv
// Small result buffer: takes up to two tokens per cycle, hands out one beat.
// Depends on stc_pkg.
module stc_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  stc_pkg::token_t     push_data_i [2],
  input  logic                pop_i,
  output stc_pkg::token_t     head_o,
  output stc_pkg::fifo_stat_t stat_o
);

  stc_pkg::token_t                  mem_q [stc_pkg::FIFO_DEPTH];
  logic [stc_pkg::FIFO_AW-1:0]      wr_q, rd_q;
  logic [stc_pkg::FIFO_LW-1:0]      level_q, level_d;
  logic [stc_pkg::FIFO_AW-1:0]      wr_nxt;

  assign wr_nxt = wr_q + 1'b1;

  // Entry writes
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_nxt] <= push_data_i[1];
    end
  end

  assign level_d = level_q + stc_pkg::FIFO_LW'(push_cnt_i) - stc_pkg::FIFO_LW'(pop_i);

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + stc_pkg::FIFO_AW'(push_cnt_i);
      rd_q    <= rd_q + stc_pkg::FIFO_AW'(pop_i);
      level_q <= level_d;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.valid = (level_q != '0);
  assign stat_o.room2 = (level_q <= stc_pkg::FIFO_LW'(stc_pkg::FIFO_DEPTH - 2));
  assign stat_o.level = level_q;

endmodule

### src/source_tokenizer_core.sv
// Source tokenizer: accepted input beats are registered, lexed and buffered for output.
// Throughput: one character per cycle while the result buffer has room for two tokens,
// else the input is held; the output moves one result beat per cycle while tready is high.
// Reset (async, active low): mode idle, line and column 1, length 0, buffers empty.
// Depends on stc_pkg, stc_lexer and stc_out_fifo.
module source_tokenizer_core #(
  parameter int unsigned POS_WIDTH = stc_pkg::POS_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [4:0] token_kind, [20:5] start_line,
                                      // [36:21] start_col, [52:37] text_length
  output logic        m_axis_tlast    // last
);

  logic                in_valid_q;
  logic [7:0]          ch_q;
  logic                eoi_q;
  logic                in_accept;
  logic                lex_fire;

  stc_pkg::token_t     res [2];
  logic [1:0]          res_cnt;
  stc_pkg::mode_e      lex_mode;
  stc_pkg::token_t     head;
  stc_pkg::fifo_stat_t fifo_stat;
  logic                pop;

  // Input register stage
  assign lex_fire      = in_valid_q && fifo_stat.room2;
  assign s_axis_tready = !in_valid_q || lex_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (lex_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q  <= s_axis_tdata;
      eoi_q <= s_axis_tuser;
    end
  end

  // Lexer
  stc_lexer #(
    .POS_WIDTH (POS_WIDTH)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (lex_fire),
    .ch_i       (ch_q),
    .eoi_i      (eoi_q),
    .res_o      (res),
    .res_cnt_o  (res_cnt),
    .lex_mode_o (lex_mode)
  );

  // Result buffer
  assign pop = fifo_stat.valid && m_axis_tready;

  stc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_data_i (res),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  assign m_axis_tvalid = fifo_stat.valid;
  assign m_axis_tdata  = {3'b000, head.len, head.col, head.line, head.kind};
  assign m_axis_tlast  = head.last;

  // Checks
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.level <= stc_pkg::FIFO_LW'(stc_pkg::FIFO_DEPTH))
    else $error("result buffer overflow");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (head.kind == stc_pkg::K_EOF)) |-> m_axis_tlast)
    else $error("eof beat without tlast");

  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lex_fire && eoi_q) |=> (lex_mode == stc_pkg::M_IDLE))
    else $error("lexer not idle after end of input");

  a_eoi_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lex_fire && eoi_q) |-> (res_cnt != 2'd0))
    else $error("end of input gave no result");

endmodule

### verif/source_tokenizer_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for source_tokenizer_core: drives characters over the input stream,
// predicts every token beat in-bench and compares it with the output stream.
// Depends on stc_pkg and source_tokenizer_core.
module source_tokenizer_core_test;

  localparam int unsigned RUN_LIMIT  = 2_000_000;
  localparam int unsigned LEX_LAT    = 2;
  localparam int unsigned HOLD_BEAT  = 60;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned RAND_ITEMS = 450;
  localparam logic [15:0] POS_TOP    = 16'hFFFF;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'h20;

  // One character beat waiting to go out, with the idle cycles that follow it
  typedef struct {
    logic [7:0]  ch;
    logic        eoi;
    int unsigned gap;
  } char_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] ch
  logic        s_axis_tuser = 1'b0; // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [4:0] kind, [20:5] line, [36:21] col, [52:37] length
  logic        m_axis_tlast;

  char_beat_t       pending_chars[$];
  stc_pkg::token_t  expected_tokens[$];
  char_beat_t       tx_beat;
  int unsigned      tx_wait, fill_calm;
  int unsigned      rx_wait, rx_calm;
  int unsigned      beats_seen, mismatch_cnt, cycle_cnt, n_items;
  bit               long_hold_done;

  // Lexer shadow state
  stc_pkg::mode_e   lx_mode;
  logic [15:0]      pos_line, pos_col, tk_line, tk_col, tk_len;
  stc_pkg::token_t  step_res[2];
  int               step_n;

  source_tokenizer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == POS_TOP) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Single-character tokens; -1 when c is not one
  function automatic int punct_code(input logic [7:0] c);
    case (c)
      "(":     return stc_pkg::K_LPAREN;
      ")":     return stc_pkg::K_RPAREN;
      "{":     return stc_pkg::K_LBRACE;
      "}":     return stc_pkg::K_RBRACE;
      "[":     return stc_pkg::K_LBRACK;
      "]":     return stc_pkg::K_RBRACK;
      ",":     return stc_pkg::K_COMMA;
      "+":     return stc_pkg::K_PLUS;
      "*":     return stc_pkg::K_STAR;
      "/":     return stc_pkg::K_SLASH;
      "%":     return stc_pkg::K_PERCENT;
      ";":     return stc_pkg::K_SEMI;
      ":":     return stc_pkg::K_COLON;
      default: return -1;
    endcase
  endfunction

  // Kind of the pending token when it ends without being extended
  function automatic stc_pkg::kind_e pending_kind(input stc_pkg::mode_e m);
    case (m)
      stc_pkg::M_EQ:    return stc_pkg::K_ASSIGN;
      stc_pkg::M_BANG:  return stc_pkg::K_BANG;
      stc_pkg::M_LT:    return stc_pkg::K_LT;
      stc_pkg::M_GT:    return stc_pkg::K_GT;
      stc_pkg::M_MINUS: return stc_pkg::K_MINUS;
      stc_pkg::M_UNDER: return stc_pkg::K_UNDER;
      stc_pkg::M_IDENT: return stc_pkg::K_IDENT;
      stc_pkg::M_INT:   return stc_pkg::K_INT;
      stc_pkg::M_FLOAT: return stc_pkg::K_FLOAT;
      default:          return stc_pkg::K_ERR;
    endcase
  endfunction

  // Kind of the two-character operator completed by '='
  function automatic stc_pkg::kind_e pair_kind(input stc_pkg::mode_e m);
    case (m)
      stc_pkg::M_EQ:   return stc_pkg::K_EQ;
      stc_pkg::M_BANG: return stc_pkg::K_NE;
      stc_pkg::M_LT:   return stc_pkg::K_LE;
      default:         return stc_pkg::K_GE;
    endcase
  endfunction

  task automatic put_token(input stc_pkg::kind_e k, input logic [15:0] l,
                           input logic [15:0] c, input logic [15:0] n);
    if (step_n < 2) begin
      step_res[step_n].kind = k;
      step_res[step_n].line = l;
      step_res[step_n].col  = c;
      step_res[step_n].len  = n;
      step_res[step_n].last = 1'b0;
      step_n++;
    end
  endtask

  task automatic move_pos(input logic [7:0] c);
    if (c == stc_pkg::CH_NL) begin
      pos_line = sat_up(pos_line);
      pos_col  = 16'd1;
    end else begin
      pos_col = sat_up(pos_col);
    end
  endtask

  // Character seen with nothing pending
  task automatic begin_token(input logic [7:0] c);
    int pc;
    pc      = punct_code(c);
    tk_line = pos_line;
    tk_col  = pos_col;
    tk_len  = 16'd1;
    lx_mode = stc_pkg::M_IDLE;
    if (pc >= 0) put_token(stc_pkg::kind_e'(pc[4:0]), tk_line, tk_col, 16'd1);
    else if (c == stc_pkg::CH_EQ)    lx_mode = stc_pkg::M_EQ;
    else if (c == stc_pkg::CH_BANG)  lx_mode = stc_pkg::M_BANG;
    else if (c == stc_pkg::CH_LT)    lx_mode = stc_pkg::M_LT;
    else if (c == stc_pkg::CH_GT)    lx_mode = stc_pkg::M_GT;
    else if (c == stc_pkg::CH_MINUS) lx_mode = stc_pkg::M_MINUS;
    else if (c == stc_pkg::CH_UNDER) lx_mode = stc_pkg::M_UNDER;
    else if (is_letter(c))           lx_mode = stc_pkg::M_IDENT;
    else if (is_num(c))              lx_mode = stc_pkg::M_INT;
    else if (c == stc_pkg::CH_QUOTE) lx_mode = stc_pkg::M_STRING;
    move_pos(c);
    // string text starts after the opening quote
    if (lx_mode == stc_pkg::M_STRING) begin
      tk_line = pos_line;
      tk_col  = pos_col;
      tk_len  = 16'd0;
    end
  endtask

  // Advance the shadow lexer by one accepted beat and queue what it emits
  task automatic lex_char(input logic [7:0] c, input logic eoi);
    step_n = 0;
    if (eoi) begin
      if (lx_mode != stc_pkg::M_IDLE) begin
        put_token(pending_kind(lx_mode), tk_line, tk_col, tk_len);
      end
      lx_mode = stc_pkg::M_IDLE;
      put_token(stc_pkg::K_EOF, pos_line, pos_col, 16'd0);
    end else begin
      case (lx_mode) inside
        stc_pkg::M_EQ, stc_pkg::M_BANG, stc_pkg::M_LT, stc_pkg::M_GT: begin
          if (c == stc_pkg::CH_EQ) begin
            put_token(pair_kind(lx_mode), tk_line, tk_col, 16'd2);
            lx_mode = stc_pkg::M_IDLE;
            move_pos(c);
          end else begin
            put_token(pending_kind(lx_mode), tk_line, tk_col, 16'd1);
            begin_token(c);
          end
        end
        stc_pkg::M_MINUS: begin
          if (c == stc_pkg::CH_GT) begin
            put_token(stc_pkg::K_ARROW, tk_line, tk_col, 16'd2);
            lx_mode = stc_pkg::M_IDLE;
            move_pos(c);
          end else begin
            put_token(stc_pkg::K_MINUS, tk_line, tk_col, 16'd1);
            begin_token(c);
          end
        end
        stc_pkg::M_UNDER: begin
          if (is_letter(c)) begin
            tk_len  = sat_up(tk_len);
            lx_mode = stc_pkg::M_IDENT;
            move_pos(c);
          end else begin
            put_token(stc_pkg::K_UNDER, tk_line, tk_col, 16'd1);
            begin_token(c);
          end
        end
        stc_pkg::M_IDENT, stc_pkg::M_INT, stc_pkg::M_FLOAT: begin
          if ((lx_mode == stc_pkg::M_IDENT &&
               (is_letter(c) || is_num(c) || c == stc_pkg::CH_UNDER)) ||
              (lx_mode == stc_pkg::M_INT && (is_num(c) || c == stc_pkg::CH_DOT)) ||
              (lx_mode == stc_pkg::M_FLOAT && is_num(c))) begin
            tk_len = sat_up(tk_len);
            if (lx_mode == stc_pkg::M_INT && c == stc_pkg::CH_DOT) begin
              lx_mode = stc_pkg::M_FLOAT;
            end
            move_pos(c);
          end else begin
            put_token(pending_kind(lx_mode), tk_line, tk_col, tk_len);
            begin_token(c);
          end
        end
        stc_pkg::M_STRING: begin
          if (c == stc_pkg::CH_QUOTE) begin
            put_token(stc_pkg::K_STRING, tk_line, tk_col, tk_len);
            lx_mode = stc_pkg::M_IDLE;
          end else if (c == stc_pkg::CH_NL) begin
            put_token(stc_pkg::K_ERR, tk_line, tk_col, tk_len);
            lx_mode = stc_pkg::M_IDLE;
          end else begin
            tk_len = sat_up(tk_len);
          end
          move_pos(c);
        end
        default: begin_token(c);
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) begin
      expected_tokens.insert(expected_tokens.size(), step_res[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_ch(input logic [7:0] c);
    char_beat_t b;
    b.ch  = c;
    b.eoi = 1'b0;
    b.gap = idle_len(fill_calm);
    pending_chars.insert(pending_chars.size(), b);
    n_items++;
  endtask

  task automatic put_end();
    char_beat_t b;
    b.ch  = 8'($urandom_range(0, 255));
    b.eoi = 1'b1;
    b.gap = idle_len(fill_calm);
    pending_chars.insert(pending_chars.size(), b);
    n_items++;
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      2:       return 8'("0" + $urandom_range(0, 9));
      default: return stc_pkg::CH_UNDER;
    endcase
  endfunction

  // One random lexeme; adjacent lexemes interact through the lookahead
  task automatic put_random_lexeme();
    string       punct_set;
    string       op_set;
    int unsigned n, r;
    logic [7:0]  c;
    punct_set = "(){}[],+*/%;:";
    op_set    = "=!<>-_";
    case ($urandom_range(0, 11)) inside
      0, 1: put_ch(punct_set[$urandom_range(0, 12)]);
      2: begin
        r = $urandom_range(0, 4);
        if (r == 4) begin
          put_ch(stc_pkg::CH_MINUS);
          put_ch(stc_pkg::CH_GT);
        end else begin
          put_ch(op_set[r]);
          put_ch(stc_pkg::CH_EQ);
        end
      end
      3: put_ch(op_set[$urandom_range(0, 5)]);
      4, 5: begin
        if ($urandom_range(0, 3) == 0) put_ch(stc_pkg::CH_UNDER);
        put_ch(8'("a" + $urandom_range(0, 25)));
        n = $urandom_range(0, 7);
        repeat (n) put_ch(word_char());
      end
      6: begin
        n = $urandom_range(1, 5);
        repeat (n) put_ch(8'("0" + $urandom_range(0, 9)));
      end
      7: begin
        n = $urandom_range(1, 4);
        repeat (n) put_ch(8'("0" + $urandom_range(0, 9)));
        put_ch(stc_pkg::CH_DOT);
        n = $urandom_range(0, 3);
        repeat (n) put_ch(8'("0" + $urandom_range(0, 9)));
      end
      8: begin
        put_ch(stc_pkg::CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          if (c == stc_pkg::CH_QUOTE || c == stc_pkg::CH_NL) c = "s";
          put_ch(c);
        end
        r = $urandom_range(0, 99);
        if (r < 80) put_ch(stc_pkg::CH_QUOTE);
        else if (r < 92) put_ch(stc_pkg::CH_NL);
        else put_end();
      end
      9: begin
        r = $urandom_range(0, 3);
        put_ch(r == 0 ? CH_SPACE : r == 1 ? CH_TAB : r == 2 ? CH_CR : stc_pkg::CH_NL);
      end
      10: put_ch(8'($urandom_range(0, 255)));
      default: begin
        if ($urandom_range(0, 2) == 0) put_end();
        else put_ch(CH_SPACE);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one beat per handshake, idle cycles as queued
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      tx_wait = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) lex_char(s_axis_tdata, s_axis_tuser);
      if (tx_wait != 0 || pending_chars.size() == 0) begin
        if (tx_wait != 0) tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else begin
        tx_beat = pending_chars.pop_front();
        s_axis_tdata  <= tx_beat.ch;
        s_axis_tuser  <= tx_beat.eoi;
        s_axis_tvalid <= 1'b1;
        tx_wait = tx_beat.gap;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each token beat and throttles tready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected token beat kind %0d line %0d col %0d len %0d last %0d",
                   $time, m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tdata[36:21],
                   m_axis_tdata[52:37], m_axis_tlast);
        end else begin
          stc_pkg::token_t want;
          want = expected_tokens.pop_front();
          if (want.kind !== m_axis_tdata[4:0] || want.line !== m_axis_tdata[20:5] ||
              want.col !== m_axis_tdata[36:21] || want.len !== m_axis_tdata[52:37] ||
              want.last !== m_axis_tlast) begin
            mismatch_cnt++;
            $display("%0t: token mismatch, expected kind %0d line %0d col %0d len %0d",
                     $time, want.kind, want.line, want.col, want.len,
                     " last %0d, got kind %0d line %0d col %0d len %0d last %0d",
                     want.last, m_axis_tdata[4:0], m_axis_tdata[20:5],
                     m_axis_tdata[36:21], m_axis_tdata[52:37], m_axis_tlast);
          end
        end
        beats_seen++;
      end
      // one long hold-off so the result buffer fills and the input stalls
      if (beats_seen == HOLD_BEAT && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_wait = HOLD_LEN;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        rx_wait = idle_len(rx_calm);
        m_axis_tready <= (rx_wait == 0);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rand_start;
    lx_mode  = stc_pkg::M_IDLE;
    pos_line = 16'd1;
    pos_col  = 16'd1;
    tk_line  = 16'd1;
    tk_col   = 16'd1;
    tk_len   = 16'd0;

    // Directed: byte extremes, underscore rules, float edge, string corner cases,
    // operators pending at end of input, tab and carriage return
    put_ch(8'h00);
    put_ch(8'hFF);
    put_ch(stc_pkg::CH_UNDER);
    put_ch("a");
    put_ch(stc_pkg::CH_UNDER);
    put_ch(CH_SPACE);
    put_ch(stc_pkg::CH_UNDER);
    put_ch("1");
    put_ch(stc_pkg::CH_DOT);
    put_ch(stc_pkg::CH_DOT);
    put_ch(stc_pkg::CH_QUOTE);
    put_ch(stc_pkg::CH_QUOTE);
    put_ch(stc_pkg::CH_QUOTE);
    put_ch("x");
    put_ch(stc_pkg::CH_NL);
    put_ch(stc_pkg::CH_MINUS);
    put_ch(stc_pkg::CH_GT);
    put_ch(stc_pkg::CH_BANG);
    put_ch(stc_pkg::CH_EQ);
    put_ch(stc_pkg::CH_LT);
    put_ch(stc_pkg::CH_QUOTE);
    put_end();
    put_ch(stc_pkg::CH_EQ);
    put_end();
    put_ch(CH_TAB);
    put_ch(CH_CR);

    // Random lexeme streams
    rand_start = n_items;
    while (n_items - rand_start < RAND_ITEMS) put_random_lexeme();
    put_ch("x");
    put_ch(stc_pkg::CH_GT);
    put_end();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: wait until all beats are accepted and all tokens seen, then let the bench settle
    while (pending_chars.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (LEX_LAT * 10) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
